// File: rtl/core/slt_pkg.sv
// shared codes and controller/datapath interface types for the sorted list table
package slt_pkg;

  // field widths fixed by the item format
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int POS_W     = 6;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 7;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
  localparam logic [OP_W-1:0] OP_PRESENT = 3'd3;
  localparam logic [OP_W-1:0] OP_COUNT   = 3'd4;
  localparam logic [OP_W-1:0] OP_READ    = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  // read address select
  localparam logic [2:0] RA_IDX_M1 = 3'd0;
  localparam logic [2:0] RA_IDX_M2 = 3'd1;
  localparam logic [2:0] RA_IDX    = 3'd2;
  localparam logic [2:0] RA_IDX_P1 = 3'd3;
  localparam logic [2:0] RA_POS    = 3'd4;

  // write kind select
  localparam logic [1:0] WR_NONE       = 2'd0;
  localparam logic [1:0] WR_SHIFT_UP   = 2'd1;  // mem[idx]   <= read data
  localparam logic [1:0] WR_PUT        = 2'd2;  // mem[idx]   <= item value
  localparam logic [1:0] WR_SHIFT_DOWN = 2'd3;  // mem[idx-1] <= read data

  // commands from controller to datapath
  typedef struct packed {
    logic                load;
    logic                cnt_clear;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                idx_from_cnt;
    logic                idx_zero;
    logic                idx_dec;
    logic                idx_inc;
    logic [2:0]          rd_sel;
    logic [1:0]          wr_sel;
    logic                hit_clear;
    logic                hit_set;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
    logic                res_found;
    logic                res_rd;
    logic                out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            cnt_zero;
    logic            cnt_full;
    logic            pos_bad;
    logic            idx_one;
    logic            idx_last;
    logic            ge;
    logic            eq;
    logic            hit;
  } sts_t;

endpackage

// File: rtl/core/slt_ram.sv
// generic single write port, single read port ram with registered read
module slt_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/slt_dpath.sv
// datapath: item registers, count, scan index, entry ram and result registers
module slt_dpath #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  slt_pkg::cmd_t                       cmd,
  output slt_pkg::sts_t                       sts,
  input  logic [slt_pkg::OP_W-1:0]            in_operation,
  input  logic signed [slt_pkg::DATA_W-1:0]   in_value,
  input  logic [slt_pkg::POS_W-1:0]           in_position,
  output logic [slt_pkg::STATUS_W-1:0]        out_status,
  output logic                                out_found,
  output logic signed [slt_pkg::DATA_W-1:0]   out_read_value,
  output logic [slt_pkg::CNT_OUT_W-1:0]       out_entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > slt_pkg::CNT_OUT_W) ? CW : slt_pkg::CNT_OUT_W;
  localparam int PW = (CW > slt_pkg::POS_W) ? CW : slt_pkg::POS_W;

  logic [slt_pkg::OP_W-1:0]     op_r;
  logic [slt_pkg::DATA_W-1:0]   val_r;
  logic [slt_pkg::POS_W-1:0]    pos_r;
  logic [CW-1:0]                count_r, count_nxt;
  logic [CW-1:0]                idx_r, idx_nxt;
  logic                         hit_r;
  logic [slt_pkg::STATUS_W-1:0] res_status_r;
  logic                         res_found_r;
  logic [slt_pkg::DATA_W-1:0]   res_rd_r;
  logic [slt_pkg::STATUS_W-1:0] out_status_r;
  logic                         out_found_r;
  logic [slt_pkg::DATA_W-1:0]   out_read_value_r;
  logic [slt_pkg::CNT_OUT_W-1:0] out_entry_count_r;

  logic [CW-1:0]                idx_m1, idx_m2, idx_p1;
  logic [PW-1:0]                pos_ext;
  logic [EW-1:0]                cnt_ext;
  logic [AW-1:0]                raddr, waddr;
  logic                         we;
  logic [slt_pkg::DATA_W-1:0]   wdata, rdata;

  assign idx_m1  = idx_r - CW'(1);
  assign idx_m2  = idx_r - CW'(2);
  assign idx_p1  = idx_r + CW'(1);
  assign pos_ext = PW'(pos_r);
  assign cnt_ext = EW'(count_r);

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      val_r <= in_value;
      pos_r <= in_position;
    end
  end

  // stored count
  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_clear) begin
      count_nxt = '0;
    end else if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // scan index and match flag
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_from_cnt) begin
      idx_nxt = count_r;
    end else if (cmd.idx_zero) begin
      idx_nxt = '0;
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_m1;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_p1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      hit_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (cmd.hit_clear) begin
        hit_r <= 1'b0;
      end else if (cmd.hit_set) begin
        hit_r <= 1'b1;
      end
    end
  end

  // ram read address
  always_comb begin
    unique case (cmd.rd_sel)
      slt_pkg::RA_IDX_M1: raddr = idx_m1[AW-1:0];
      slt_pkg::RA_IDX_M2: raddr = idx_m2[AW-1:0];
      slt_pkg::RA_IDX_P1: raddr = idx_p1[AW-1:0];
      slt_pkg::RA_POS:    raddr = pos_ext[AW-1:0];
      default:            raddr = idx_r[AW-1:0];
    endcase
  end

  // ram write port
  always_comb begin
    we    = 1'b0;
    waddr = idx_r[AW-1:0];
    wdata = rdata;
    unique case (cmd.wr_sel)
      slt_pkg::WR_SHIFT_UP: begin
        we = 1'b1;
      end
      slt_pkg::WR_PUT: begin
        we    = 1'b1;
        wdata = val_r;
      end
      slt_pkg::WR_SHIFT_DOWN: begin
        we    = 1'b1;
        waddr = idx_m1[AW-1:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  slt_ram #(
    .WIDTH (slt_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // status to controller
  always_comb begin
    sts.op       = op_r;
    sts.cnt_zero = (count_r == '0);
    sts.cnt_full = (count_r >= CW'(CAPACITY));
    sts.pos_bad  = (pos_ext >= PW'(count_r));
    sts.idx_one  = (idx_r == CW'(1));
    sts.idx_last = (idx_p1 == count_r);
    sts.ge       = ($signed(rdata) >= $signed(val_r));
    sts.eq       = (rdata == val_r);
    sts.hit      = hit_r;
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      res_found_r  <= cmd.res_found;
      res_rd_r     <= cmd.res_rd ? rdata : '0;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r      <= res_status_r;
      out_found_r       <= res_found_r;
      out_read_value_r  <= res_rd_r;
      out_entry_count_r <= cnt_ext[slt_pkg::CNT_OUT_W-1:0];
    end
  end

  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_read_value  = out_read_value_r;
  assign out_entry_count = out_entry_count_r;

endmodule

// File: rtl/core/slt_ctrl.sv
// controller: sequences each operation over the entry ram and runs the handshakes
module slt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  slt_pkg::sts_t sts,
  output slt_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_INS_RD  = 4'd2;
  localparam logic [3:0] S_INS_CMP = 4'd3;
  localparam logic [3:0] S_INS_PUT = 4'd4;
  localparam logic [3:0] S_SCAN_RD = 4'd5;
  localparam logic [3:0] S_SCAN    = 4'd6;
  localparam logic [3:0] S_RD_WAIT = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.rd_sel     = slt_pkg::RA_IDX;
    cmd.wr_sel     = slt_pkg::WR_NONE;
    cmd.res_status = slt_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.op) inside
          slt_pkg::OP_CLEAR: begin
            cmd.cnt_clear = 1'b1;
            cmd.res_load  = 1'b1;
            state_nxt     = S_DONE;
          end
          slt_pkg::OP_INSERT: begin
            if (sts.cnt_full) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = slt_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              cmd.idx_from_cnt = 1'b1;
              state_nxt = sts.cnt_zero ? S_INS_PUT : S_INS_RD;
            end
          end
          slt_pkg::OP_REMOVE, slt_pkg::OP_PRESENT: begin
            if (sts.cnt_zero) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = (sts.op == slt_pkg::OP_REMOVE) ?
                               slt_pkg::ST_NOT_FOUND : slt_pkg::ST_OK;
              state_nxt      = S_DONE;
            end else begin
              cmd.idx_zero  = 1'b1;
              cmd.hit_clear = 1'b1;
              state_nxt     = S_SCAN_RD;
            end
          end
          slt_pkg::OP_READ: begin
            if (sts.pos_bad) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = slt_pkg::ST_RANGE;
              state_nxt      = S_DONE;
            end else begin
              cmd.rd_sel = slt_pkg::RA_POS;
              state_nxt  = S_RD_WAIT;
            end
          end
          default: begin
            // count and unused codes report only
            cmd.res_load = 1'b1;
            state_nxt    = S_DONE;
          end
        endcase
      end
      // fetch the top entry for the backward shift
      S_INS_RD: begin
        cmd.rd_sel = slt_pkg::RA_IDX_M1;
        state_nxt  = S_INS_CMP;
      end
      // read data holds entry idx-1; move it up while it is not below the value
      S_INS_CMP: begin
        cmd.rd_sel = slt_pkg::RA_IDX_M2;
        if (sts.ge) begin
          cmd.wr_sel  = slt_pkg::WR_SHIFT_UP;
          cmd.idx_dec = 1'b1;
          if (sts.idx_one) begin
            state_nxt = S_INS_PUT;
          end
        end else begin
          cmd.wr_sel   = slt_pkg::WR_PUT;
          cmd.cnt_inc  = 1'b1;
          cmd.res_load = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_INS_PUT: begin
        cmd.wr_sel   = slt_pkg::WR_PUT;
        cmd.cnt_inc  = 1'b1;
        cmd.res_load = 1'b1;
        state_nxt    = S_DONE;
      end
      S_SCAN_RD: begin
        cmd.rd_sel = slt_pkg::RA_IDX;
        state_nxt  = S_SCAN;
      end
      // forward scan; remove closes the gap behind the first match
      S_SCAN: begin
        cmd.rd_sel = slt_pkg::RA_IDX_P1;
        if (sts.op == slt_pkg::OP_PRESENT) begin
          if (sts.eq || sts.idx_last) begin
            cmd.res_load  = 1'b1;
            cmd.res_found = sts.eq;
            state_nxt     = S_DONE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end else begin
          if (sts.hit) begin
            cmd.wr_sel = slt_pkg::WR_SHIFT_DOWN;
          end else if (sts.eq) begin
            cmd.hit_set = 1'b1;
          end
          if (sts.idx_last) begin
            cmd.res_load = 1'b1;
            if (sts.hit || sts.eq) begin
              cmd.cnt_dec = 1'b1;
            end else begin
              cmd.res_status = slt_pkg::ST_NOT_FOUND;
            end
            state_nxt = S_DONE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_RD_WAIT: begin
        cmd.res_load = 1'b1;
        cmd.res_rd   = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/core/sorted_list_table.sv
// Sorted table of signed words: clear, insert, remove, present, count, read position.
// Clear, count, full and out of range report from dispatch, as do remove and present on an
// empty table; read position adds a ram read; insert moves entries not below the value up
// from the top, or puts at once into an empty table; remove and present scan forward.
// One item at a time, as in_stall is high outside the idle state; a finished word waits in the output register.
// Synchronous active-low reset empties the table (count zero); entries need no clearing.
module sorted_list_table #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [slt_pkg::OP_W-1:0]            in_operation,
  input  logic signed [slt_pkg::DATA_W-1:0]   in_value,
  input  logic [slt_pkg::POS_W-1:0]           in_position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [slt_pkg::STATUS_W-1:0]        out_status,
  output logic                                out_found,
  output logic signed [slt_pkg::DATA_W-1:0]   out_read_value,
  output logic [slt_pkg::CNT_OUT_W-1:0]       out_entry_count
);

  slt_pkg::cmd_t cmd;
  slt_pkg::sts_t sts;

  // sequencer
  slt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage and compare logic
  slt_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count)
  );

endmodule
